[src/hksm_pkg.sv]
`timescale 1ns / 1ps

package hksm_pkg;

	// item field widths
	localparam int KEY_W  = 10;
	localparam int TIME_W = 64;
	localparam int VERD_W = 2;
	localparam int DATA_W = 80;

	// key codes with a special meaning
	localparam logic [KEY_W-1:0] KEY_BKSP      = 10'd14;
	localparam logic [KEY_W-1:0] KEY_TAB       = 10'd15;
	localparam logic [KEY_W-1:0] KEY_RETURN    = 10'd28;
	localparam logic [KEY_W-1:0] KEY_SPC       = 10'd57;
	localparam logic [KEY_W-1:0] KEY_CAPS      = 10'd58;
	localparam logic [KEY_W-1:0] KEY_PAD_ENTER = 10'd96;

	// verdict codes
	localparam logic [VERD_W-1:0] VERDICT_PASS    = 2'd0;
	localparam logic [VERD_W-1:0] VERDICT_DISCARD = 2'd1;
	localparam logic [VERD_W-1:0] VERDICT_INJECT  = 2'd2;

	// register byte address
	localparam logic [2:0] REG_START_ENABLED = 3'd0;

	typedef enum logic [2:0] {
		MODE_IDLE     = 3'b001,
		MODE_PRESSED  = 3'b010,
		MODE_MODIFIED = 3'b100
	} mode_t;

	typedef struct packed {
		logic [KEY_W-1:0]  code;
		logic              pressed;
		logic [TIME_W-1:0] stamp;
		logic [VERD_W-1:0] verdict;
		logic              last;
	} res_t;

	// mirror of a key: four rows of ten reflected, backspace/tab and enter/capslock swapped
	function automatic logic [KEY_W-1:0] mirror_code(input logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] m;
		m = k;
		if (k >= 10'd2 && k <= 10'd11)
			m = 10'd13 - k;
		else if (k >= 10'd16 && k <= 10'd25)
			m = 10'd41 - k;
		else if (k >= 10'd30 && k <= 10'd39)
			m = 10'd69 - k;
		else if (k >= 10'd44 && k <= 10'd53)
			m = 10'd97 - k;
		else if (k == KEY_BKSP)
			m = KEY_TAB;
		else if (k == KEY_TAB)
			m = KEY_BKSP;
		else if (k == KEY_RETURN)
			m = KEY_CAPS;
		else if (k == KEY_CAPS)
			m = KEY_RETURN;
		return m;
	endfunction

endpackage

[src/half_keyboard_space_mirror_filter_core.sv]
`timescale 1ns / 1ps

// Half-keyboard space mirror filter.
// Input stream (s_*): one key event per item; s_tdata holds key code, press flag
// and 64-bit time stamp. Output stream (m_*): one to three items per event, an
// optional queued space press, an optional injected mirror event and always a
// final verdict item marked by m_tlast; m_tuser carries the verdict.
// APB port: register 0 (start_enabled) at byte address 0; writing it also loads
// the live enable flag. Write it only while the block is idle.
// An accepted event is registered in the processing stage, then committed to
// the output queue. Throughput: one event per cycle when each event yields one
// result and the receiver does not stall; an event with several results holds
// the next commit until its last result is being taken. The held-mirror memory
// (one bit per key, two registered read ports, one write port) is read on accept
// and written back on commit, with a bypass for a write to the address being read.
// Reset: mode goes idle, enable and queued space clear, and the memory is
// cleared by a sweep over all KEY_COUNT entries during which s_tready stays low.
// When the receiver stalls, up to three results wait in the output queue and
// one more event waits in the processing stage; then s_tready drops.
module half_keyboard_space_mirror_filter_core #(
	parameter int KEY_COUNT = 768
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// s_tdata: [9:0] key_code, [10] press, [74:11] event_time, [79:75] zero
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [hksm_pkg::DATA_W-1:0] s_tdata,
	// m_tdata: [9:0] out_key_code, [10] out_pressed, [74:11] out_time, [79:75] zero
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [hksm_pkg::DATA_W-1:0] m_tdata,
	// m_tuser: [1:0] verdict
	output logic [hksm_pkg::VERD_W-1:0] m_tuser,
	output logic                       m_tlast,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	import hksm_pkg::*;

	localparam int AW = $clog2(KEY_COUNT);
	localparam logic [KEY_W:0] KEY_LIMIT = (KEY_W + 1)'(KEY_COUNT);
	localparam logic [AW-1:0] CLR_LAST = AW'(KEY_COUNT - 1);

	// held-mirror memory
	logic mem [KEY_COUNT];
	logic mem_we;
	logic [AW-1:0] mem_wa;
	logic mem_wd;

	// clearing sweep
	logic clr_busy_q;
	logic [AW-1:0] clr_cnt_q;

	// architectural state
	mode_t mode_q;
	logic enable_q;
	logic start_enabled_q;
	logic [TIME_W-1:0] qtime_q;

	// processing stage
	logic s1_valid_q;
	logic [KEY_W-1:0] key_s1;
	logic [KEY_W-1:0] mk_s1;
	logic press_s1;
	logic [TIME_W-1:0] time_s1;
	logic key_ok_s1;
	logic mk_ok_s1;
	logic rd_key_s1;
	logic rd_mk_s1;

	// output queue
	res_t ob_q [3];
	logic [1:0] ob_cnt_q;

	// input decode
	logic [KEY_W-1:0] in_key;
	logic [KEY_W-1:0] in_mk;
	logic s_acc;
	logic m_acc;
	logic commit;
	logic ob_free;
	logic cfg_wr;

	// commit results
	mode_t mode_d;
	mode_t mode_cur;
	logic enable_d;
	logic [TIME_W-1:0] qtime_d;
	logic [VERD_W-1:0] verd;
	logic emit_space;
	logic emit_inj;
	logic inj_we;
	res_t new_res [3];
	logic [1:0] new_cnt;

	assign in_key = s_tdata[KEY_W-1:0];
	assign in_mk  = mirror_code(in_key);
	assign m_acc  = m_tvalid && m_tready;
	assign ob_free = (ob_cnt_q == 2'd0) || (ob_cnt_q == 2'd1 && m_acc);
	assign commit = s1_valid_q && ob_free;
	assign s_tready = !clr_busy_q && (!s1_valid_q || commit);
	assign s_acc = s_tvalid && s_tready;
	assign cfg_wr = psel && penable && pwrite && pready;

	// memory write port: sweep after reset, else commit write-back
	always_comb begin
		if (clr_busy_q) begin
			mem_we = 1'b1;
			mem_wa = clr_cnt_q;
			mem_wd = 1'b0;
		end else begin
			mem_we = commit && inj_we;
			mem_wa = mk_s1[AW-1:0];
			mem_wd = press_s1;
		end
	end

	// memory with registered reads and write bypass
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (s_acc) begin
			rd_key_s1 <= (mem_we && mem_wa == in_key[AW-1:0]) ? mem_wd : mem[in_key[AW-1:0]];
			rd_mk_s1  <= (mem_we && mem_wa == in_mk[AW-1:0]) ? mem_wd : mem[in_mk[AW-1:0]];
		end
	end

	// clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == CLR_LAST)
				clr_busy_q <= 1'b0;
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (s_acc)
			s1_valid_q <= 1'b1;
		else if (commit)
			s1_valid_q <= 1'b0;
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (s_acc) begin
			key_s1    <= in_key;
			mk_s1     <= in_mk;
			press_s1  <= s_tdata[KEY_W];
			time_s1   <= s_tdata[KEY_W+TIME_W:KEY_W+1];
			key_ok_s1 <= {1'b0, in_key} < KEY_LIMIT;
			mk_ok_s1  <= {1'b0, in_mk} < KEY_LIMIT;
		end
	end

	// event evaluation
	always_comb begin
		logic hk;
		logic hm;
		hk = key_ok_s1 && rd_key_s1;
		hm = mk_ok_s1 && rd_mk_s1;
		mode_d = mode_q;
		enable_d = enable_q;
		qtime_d = qtime_q;
		verd = VERDICT_PASS;
		emit_space = 1'b0;
		emit_inj = 1'b0;
		case (mode_q)
			MODE_PRESSED:  mode_cur = MODE_PRESSED;
			MODE_MODIFIED: mode_cur = MODE_MODIFIED;
			default:       mode_cur = MODE_IDLE;
		endcase
		if (key_s1 == KEY_PAD_ENTER) begin
			if (press_s1)
				enable_d = !enable_q;
			mode_d = MODE_IDLE;
			verd = VERDICT_DISCARD;
		end else if (enable_q) begin
			mode_d = mode_cur;
			if (key_s1 == KEY_SPC) begin
				if (press_s1) begin
					if (mode_cur == MODE_IDLE) begin
						mode_d = MODE_PRESSED;
						qtime_d = time_s1;
					end
					verd = VERDICT_DISCARD;
				end else if (mode_cur == MODE_PRESSED) begin
					mode_d = MODE_IDLE;
				end else if (mode_cur == MODE_MODIFIED) begin
					mode_d = MODE_IDLE;
					verd = VERDICT_DISCARD;
				end
			end else if (mk_s1 != key_s1) begin
				if (mode_cur == MODE_PRESSED && press_s1) begin
					mode_d = MODE_MODIFIED;
					verd = VERDICT_INJECT;
				end else if (mode_cur == MODE_MODIFIED) begin
					verd = VERDICT_INJECT;
				end
			end else if (mode_cur == MODE_PRESSED) begin
				mode_d = MODE_IDLE;
			end
			// queued space leaves on return to idle, dropped once modified
			if (mode_d != mode_cur) begin
				if (mode_d == MODE_IDLE) begin
					if (qtime_q != '0) begin
						emit_space = 1'b1;
						qtime_d = '0;
					end
				end else if (mode_d == MODE_MODIFIED) begin
					qtime_d = '0;
				end
			end
			// release of a key whose press went out mirrored
			if (!press_s1 && verd != VERDICT_INJECT && !hk && hm)
				verd = VERDICT_INJECT;
			emit_inj = (verd == VERDICT_INJECT);
		end
		inj_we = emit_inj && mk_ok_s1;
	end

	// result list for this event
	always_comb begin
		res_t sp;
		res_t ij;
		res_t fin;
		sp  = '{code: KEY_SPC, pressed: 1'b1, stamp: qtime_q,
			verdict: VERDICT_PASS, last: 1'b0};
		ij  = '{code: mk_s1, pressed: press_s1, stamp: time_s1,
			verdict: VERDICT_PASS, last: 1'b0};
		fin = '{code: key_s1, pressed: press_s1, stamp: time_s1,
			verdict: verd, last: 1'b1};
		new_res[0] = fin;
		new_res[1] = fin;
		new_res[2] = fin;
		if (emit_space && emit_inj) begin
			new_res[0] = sp;
			new_res[1] = ij;
			new_cnt = 2'd3;
		end else if (emit_space) begin
			new_res[0] = sp;
			new_cnt = 2'd2;
		end else if (emit_inj) begin
			new_res[0] = ij;
			new_cnt = 2'd2;
		end else begin
			new_cnt = 2'd1;
		end
	end

	// state update and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MODE_IDLE;
			enable_q        <= 1'b0;
			start_enabled_q <= 1'b0;
			qtime_q         <= '0;
		end else if (cfg_wr) begin
			if (paddr == REG_START_ENABLED) begin
				start_enabled_q <= pwdata[0];
				enable_q        <= pwdata[0];
			end
		end else if (commit) begin
			mode_q   <= mode_d;
			enable_q <= enable_d;
			qtime_q  <= qtime_d;
		end
	end

	// output queue count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ob_cnt_q <= 2'd0;
		else if (commit)
			ob_cnt_q <= new_cnt;
		else if (m_acc)
			ob_cnt_q <= ob_cnt_q - 2'd1;
	end

	// output queue entries, head at index 0
	always_ff @(posedge clk) begin
		if (commit) begin
			ob_q[0] <= new_res[0];
			ob_q[1] <= new_res[1];
			ob_q[2] <= new_res[2];
		end else if (m_acc) begin
			ob_q[0] <= ob_q[1];
			ob_q[1] <= ob_q[2];
		end
	end

	assign m_tvalid = (ob_cnt_q != 2'd0);
	assign m_tdata  = {5'b0, ob_q[0].stamp, ob_q[0].pressed, ob_q[0].code};
	assign m_tuser  = ob_q[0].verdict;
	assign m_tlast  = ob_q[0].last;

	// register read-back
	assign pready = 1'b1;
	assign prdata = (paddr == REG_START_ENABLED) ? {31'b0, start_enabled_q} : 32'b0;

	// no event enters during the clearing sweep
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !s_tready)
		else $error("event accepted during memory clear");

	// only the final queued result carries tlast
	a_last_at_tail: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (ob_cnt_q == 2'd1)))
		else $error("tlast out of place in output queue");

	// a commit never overwrites pending results
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> (ob_cnt_q == 2'd0 || (ob_cnt_q == 2'd1 && m_tready)))
		else $error("commit into busy output queue");

	// the output queue grows only by a commit
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		ob_cnt_q != 2'd0 |=> ob_cnt_q <= $past(ob_cnt_q) || $past(commit))
		else $error("output queue grew without commit");

endmodule

[test/half_keyboard_space_mirror_filter_core_tb.sv]
`timescale 1ns / 1ps

module half_keyboard_space_mirror_filter_core_tb;
	import hksm_pkg::*;

	localparam int KEY_COUNT   = 768;
	localparam int ROW_LEN     = 10;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PAD_W       = DATA_W - KEY_W - 1 - TIME_W;

	// first key of the number, top, home and bottom rows
	localparam logic [3:0][KEY_W-1:0] ROW_FIRST = {10'd44, 10'd30, 10'd16, 10'd2};

	typedef struct packed {
		logic [KEY_W-1:0]  code;
		logic              press;
		logic [TIME_W-1:0] stamp;
	} key_event_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;
	logic [VERD_W-1:0] m_tuser;
	logic              m_tlast;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	// events waiting to be sent, and results the filter still owes
	key_event_t key_events[$];
	res_t       owed_results[$];

	int errors;
	int events_queued;
	int events_taken;
	int cycle_count;
	int send_gap;
	int send_calm;
	int stall_left;
	int stall_calm;
	logic in_taken;

	// shadow of the filter state
	mode_t            cur_mode;
	logic             mirror_on;
	logic [TIME_W-1:0] space_stamp;
	logic [KEY_COUNT-1:0] held_keys;

	half_keyboard_space_mirror_filter_core #(
		.KEY_COUNT(KEY_COUNT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// reflect a key within its row, or swap the two pairs; other keys stay
	function automatic logic [KEY_W-1:0] reflect_key(input logic [KEY_W-1:0] k);
		for (int r = 0; r < 4; r++) begin
			if (k >= ROW_FIRST[r] && k < ROW_FIRST[r] + ROW_LEN)
				return KEY_W'(ROW_FIRST[r] + (ROW_LEN - 1) - (k - ROW_FIRST[r]));
		end
		if (k == KEY_BKSP)
			return KEY_TAB;
		if (k == KEY_TAB)
			return KEY_BKSP;
		if (k == KEY_RETURN)
			return KEY_CAPS;
		if (k == KEY_CAPS)
			return KEY_RETURN;
		return k;
	endfunction

	// codes past the store read as not held
	function automatic logic key_held(input logic [KEY_W-1:0] k);
		if (k >= KEY_COUNT)
			return 1'b0;
		return held_keys[k];
	endfunction

	function automatic void owe_result(input logic [KEY_W-1:0] code, input logic pr,
			input logic [TIME_W-1:0] stamp, input logic [VERD_W-1:0] verdict, input logic last);
		res_t r;
		r.code    = code;
		r.pressed = pr;
		r.stamp   = stamp;
		r.verdict = verdict;
		r.last    = last;
		owed_results.push_back(r);
	endfunction

	// work out the results of one key event and advance the shadow state
	task automatic filter_event(input logic [KEY_W-1:0] key, input logic pr,
			input logic [TIME_W-1:0] t);
		logic [KEY_W-1:0]  mk;
		logic [VERD_W-1:0] verdict;
		mode_t             prev_mode;
		// keypad enter: toggle on press, back to idle, always dropped
		if (key == KEY_PAD_ENTER) begin
			if (pr)
				mirror_on = ~mirror_on;
			cur_mode = MODE_IDLE;
			owe_result(key, pr, t, VERDICT_DISCARD, 1'b1);
			return;
		end
		if (!mirror_on) begin
			owe_result(key, pr, t, VERDICT_PASS, 1'b1);
			return;
		end
		mk        = reflect_key(key);
		prev_mode = cur_mode;
		verdict   = VERDICT_PASS;
		if (key == KEY_SPC) begin
			if (pr) begin
				if (prev_mode == MODE_IDLE) begin
					cur_mode    = MODE_PRESSED;
					space_stamp = t;
				end
				verdict = VERDICT_DISCARD;
			end else if (prev_mode == MODE_PRESSED) begin
				cur_mode = MODE_IDLE;
			end else if (prev_mode == MODE_MODIFIED) begin
				cur_mode = MODE_IDLE;
				verdict  = VERDICT_DISCARD;
			end
		end else if (mk != key) begin
			if (prev_mode == MODE_PRESSED && pr) begin
				cur_mode = MODE_MODIFIED;
				verdict  = VERDICT_INJECT;
			end else if (prev_mode == MODE_MODIFIED) begin
				verdict = VERDICT_INJECT;
			end
		end else if (prev_mode == MODE_PRESSED) begin
			cur_mode = MODE_IDLE;
		end
		// held-back space goes out on return to idle, dropped once it modified
		if (cur_mode != prev_mode) begin
			if (cur_mode == MODE_IDLE && space_stamp != '0) begin
				owe_result(KEY_SPC, 1'b1, space_stamp, VERDICT_PASS, 1'b0);
				space_stamp = '0;
			end else if (cur_mode == MODE_MODIFIED) begin
				space_stamp = '0;
			end
		end
		// release of a key whose press went out mirrored
		if (!pr && verdict != VERDICT_INJECT && !key_held(key) && key_held(mk))
			verdict = VERDICT_INJECT;
		if (verdict == VERDICT_INJECT) begin
			if (mk < KEY_COUNT)
				held_keys[mk] = pr;
			owe_result(mk, pr, t, VERDICT_PASS, 1'b0);
		end
		owe_result(key, pr, t, verdict, 1'b1);
	endtask

	task automatic check_field(input string name, input logic [TIME_W-1:0] want,
			input logic [TIME_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// monitor: check results, then record accepted events
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (owed_results.size() == 0) begin
					$error("result with none owed: code %0d verdict %0d",
						m_tdata[KEY_W-1:0], m_tuser);
					errors++;
				end else begin
					want = owed_results.pop_front();
					check_field("out_key_code", TIME_W'(want.code),
						TIME_W'(m_tdata[KEY_W-1:0]));
					check_field("out_pressed", TIME_W'(want.pressed), TIME_W'(m_tdata[KEY_W]));
					check_field("out_time", want.stamp, m_tdata[KEY_W+TIME_W:KEY_W+1]);
					check_field("verdict", TIME_W'(want.verdict), TIME_W'(m_tuser));
					check_field("last", TIME_W'(want.last), TIME_W'(m_tlast));
				end
			end
			in_taken = s_tvalid && s_tready;
			if (in_taken) begin
				events_taken++;
				filter_event(s_tdata[KEY_W-1:0], s_tdata[KEY_W],
					s_tdata[KEY_W+TIME_W:KEY_W+1]);
			end
		end
	end

	// mostly no gap, some short ones, a few long, and calm stretches
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// driver: send events, and stall the result side at random
	always @(negedge clk) begin
		key_event_t ev;
		if (arst_n) begin
			if (!s_tvalid || in_taken) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (key_events.size() > 0) begin
					ev = key_events.pop_front();
					s_tdata  <= {{PAD_W{1'b0}}, ev.stamp, ev.press, ev.code};
					s_tvalid <= 1'b1;
					send_gap = pick_gap(send_calm);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				stall_left = pick_gap(stall_calm);
			end
		end
	end

	task automatic queue_event(input logic [KEY_W-1:0] code, input logic pr,
			input logic [TIME_W-1:0] stamp);
		key_event_t ev;
		ev.code  = code;
		ev.press = pr;
		ev.stamp = stamp;
		key_events.push_back(ev);
		events_queued++;
	endtask

	function automatic logic [TIME_W-1:0] rand_stamp();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	function automatic logic [KEY_W-1:0] rand_mirror_key();
		int r;
		r = $urandom_range(0, 5);
		if (r < 4)
			return ROW_FIRST[r] + KEY_W'($urandom_range(0, ROW_LEN - 1));
		case ($urandom_range(0, 3))
			0: return KEY_BKSP;
			1: return KEY_TAB;
			2: return KEY_RETURN;
			default: return KEY_CAPS;
		endcase
	endfunction

	// space held over a few mirrored keys; some keys let go after space
	task automatic queue_space_chord();
		logic [KEY_W-1:0] late[$];
		logic [KEY_W-1:0] k;
		int n;
		n = $urandom_range(0, 3);
		queue_event(KEY_SPC, 1'b1, rand_stamp());
		repeat (n) begin
			k = rand_mirror_key();
			queue_event(k, 1'b1, rand_stamp());
			if ($urandom_range(0, 1))
				queue_event(k, 1'b0, rand_stamp());
			else
				late.push_back(k);
		end
		if ($urandom_range(0, 4) == 0)
			queue_event(KEY_W'($urandom_range(60, 95)), 1'($urandom_range(0, 1)),
				rand_stamp());
		queue_event(KEY_SPC, 1'b0, rand_stamp());
		foreach (late[i])
			queue_event(late[i], 1'b0, rand_stamp());
	endtask

	task automatic queue_random(input int count);
		int goal;
		int r;
		goal = events_queued + count;
		while (events_queued < goal) begin
			r = $urandom_range(0, 99);
			if (r < 62)
				queue_space_chord();
			else if (r < 82)
				queue_event(KEY_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
					rand_stamp());
			else if (r < 86)
				queue_event(KEY_PAD_ENTER, 1'($urandom_range(0, 1)), rand_stamp());
			else
				queue_event(rand_mirror_key(), 1'($urandom_range(0, 1)), rand_stamp());
		end
	endtask

	// wait until every event is in and every result is out
	task automatic wait_idle();
		do
			@(negedge clk);
		while (events_taken != events_queued || owed_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_start_enabled(input logic val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_START_ENABLED;
		pwdata  <= {31'b0, val};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		mirror_on = val;
	endtask

	// timeout
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		errors        = 0;
		events_queued = 0;
		events_taken  = 0;
		send_gap      = 0;
		send_calm     = 0;
		stall_left    = 0;
		stall_calm    = 0;
		in_taken      = 1'b0;
		cur_mode      = MODE_IDLE;
		mirror_on     = 1'b0;
		space_stamp   = '0;
		held_keys     = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		m_tready      = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		arst_n        = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// mirroring off after reset: everything passes
		queue_event(10'd30, 1'b1, '1);
		queue_event(10'd1023, 1'b0, '0);
		queue_event(KEY_SPC, 1'b1, 64'd50);
		queue_event(KEY_SPC, 1'b0, 64'd51);
		wait_idle();

		write_start_enabled(1'b1);
		// space used as modifier: no space emitted
		queue_event(KEY_SPC, 1'b1, 64'd100);
		queue_event(10'd2, 1'b1, 64'd101);
		queue_event(10'd2, 1'b0, 64'd102);
		queue_event(KEY_SPC, 1'b0, 64'd103);
		// plain tap: space comes out on release
		queue_event(KEY_SPC, 1'b1, 64'd200);
		queue_event(KEY_SPC, 1'b0, 64'd201);
		// other key while space down releases the held space
		queue_event(KEY_SPC, 1'b1, 64'd300);
		queue_event(10'd1, 1'b1, 64'd301);
		// space at time zero queues nothing; repeated press dropped
		queue_event(KEY_SPC, 1'b1, 64'd0);
		queue_event(KEY_SPC, 1'b1, 64'd401);
		queue_event(10'd59, 1'b1, 64'd402);
		// release of a key whose press went out mirrored
		queue_event(KEY_SPC, 1'b1, 64'd5);
		queue_event(KEY_BKSP, 1'b1, 64'd6);
		queue_event(KEY_SPC, 1'b0, 64'd7);
		queue_event(KEY_BKSP, 1'b0, 64'd8);
		// keypad enter release forces idle but keeps the queued space
		queue_event(KEY_SPC, 1'b1, 64'd9);
		queue_event(KEY_PAD_ENTER, 1'b0, 64'd10);
		queue_event(KEY_RETURN, 1'b1, 64'd11);
		queue_event(KEY_SPC, 1'b1, 64'd13);
		queue_event(KEY_SPC, 1'b0, 64'd14);
		// keypad enter press toggles mirroring off and on
		queue_event(KEY_PAD_ENTER, 1'b1, 64'd15);
		queue_event(10'd44, 1'b1, 64'd16);
		queue_event(KEY_PAD_ENTER, 1'b1, 64'd17);
		// codes past the store
		queue_event(KEY_SPC, 1'b1, '1);
		queue_event(10'd800, 1'b1, '0);
		queue_event(10'd1023, 1'b0, '1);
		wait_idle();

		write_start_enabled(1'b0);
		queue_random(70);
		wait_idle();
		write_start_enabled(1'b1);
		queue_random(80);
		wait_idle();
		write_start_enabled(1'b0);
		write_start_enabled(1'b1);
		queue_random(80);
		wait_idle();

		repeat (20) @(negedge clk);
		if (owed_results.size() != 0) begin
			$error("%0d results never arrived", owed_results.size());
			errors++;
		end
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
